### rtl/can_rx_demux_ring_buffers_core_defines.svh
// Assertion macros for the CAN receive demux core.
`ifndef CAN_RX_DEMUX_RING_BUFFERS_CORE_DEFINES_SVH
`define CAN_RX_DEMUX_RING_BUFFERS_CORE_DEFINES_SVH

// Holds at every edge outside reset.
`define CRDRB_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CRDRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CRDRB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/crdrb_pkg.sv
// Package: command codes, field layout and types of the CAN receive demux core.
package crdrb_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [7:0] byte_t;

    localparam cmd_t CMD_STORE = 2'd0;
    localparam cmd_t CMD_CHECK = 2'd1;
    localparam cmd_t CMD_POP   = 2'd2;

    localparam int ID_SHIFT        = 4;
    localparam int INDEX_BIAS      = 1;
    localparam int MAX_FRAME_BYTES = 8;

    localparam int ID_W    = 11;
    localparam int LEN_W   = 4;
    localparam int SEL_W   = 3;
    localparam int BYTE_W  = 8;

    localparam int ID_LSB    = 0;
    localparam int LEN_LSB   = ID_LSB + ID_W;
    localparam int DATA_LSB  = LEN_LSB + LEN_W;
    localparam int DATA_W    = MAX_FRAME_BYTES * BYTE_W;
    localparam int SEL_LSB   = DATA_LSB + DATA_W;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

endpackage

### rtl/can_rx_demux_ring_buffers_core.sv
// Store cmd: accepted, then one data byte written per cycle in the write state, then the result state.
// Pop cmd: a single store read state, then the result state.
// Check cmd, dropped frames, empty stores and out-of-range pops: accept goes straight to the result state.
// The single-port byte store and the shared pointer incrementer set these steps; a new item is taken only when idle.
// Reset clears the pointers and the control state; the byte store is not cleared.
`include "can_rx_demux_ring_buffers_core_defines.svh"

module can_rx_demux_ring_buffers_core #(
    parameter int DEVICE_QUEUES = 8,
    parameter int QUEUE_BYTES   = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_id, frame_length, byte_0 .. byte_7, queue_sel, zero pad
    input  logic [crdrb_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [crdrb_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_dropped, has_data, read_byte, zero pad
    output logic [crdrb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import crdrb_pkg::*;

    localparam int QIW   = (DEVICE_QUEUES > 1) ? $clog2(DEVICE_QUEUES) : 1;
    localparam int PW    = $clog2(QUEUE_BYTES);
    localparam int AW    = QIW + PW;
    localparam int DEPTH = 1 << AW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WRITE  = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic              in_range_reg;
    logic [QIW-1:0]    q_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] bytes_reg;
    byte_t             rdata_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [PW-1:0] wp_reg [DEVICE_QUEUES];
    logic [PW-1:0] rp_reg [DEVICE_QUEUES];
    byte_t         store_mem [DEPTH];

    cmd_t             in_cmd;
    logic [ID_W-1:0]  in_id;
    logic [LEN_W-1:0] in_len, in_len_sat;
    logic [SEL_W-1:0] in_sel;
    logic [7:0]       q8, sel8, qsel8;
    logic             q_ok;
    logic             accept, out_free;
    logic [PW-1:0]    ptr_cur, ptr_adv;
    logic             res_dropped, res_has;
    byte_t            res_byte;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_cmd = s_tuser[1:0];
    assign in_id  = s_tdata[ID_LSB +: ID_W];
    assign in_len = s_tdata[LEN_LSB +: LEN_W];
    assign in_sel = s_tdata[SEL_LSB +: SEL_W];

    assign in_len_sat = (in_len > LEN_W'(MAX_FRAME_BYTES)) ? LEN_W'(MAX_FRAME_BYTES) : in_len;
    assign q8    = 8'(in_id >> ID_SHIFT) - 8'(INDEX_BIAS);
    assign sel8  = {{(8 - SEL_W){1'b0}}, in_sel};
    assign qsel8 = (in_cmd == CMD_STORE) ? q8 : sel8;
    assign q_ok  = (qsel8 < 8'(DEVICE_QUEUES));

    // shared pointer incrementer with wrap
    assign ptr_cur = (state_reg == ST_WRITE) ? wp_reg[q_reg] : rp_reg[q_reg];
    assign ptr_adv = (ptr_cur == PW'(QUEUE_BYTES - 1)) ? '0 : ptr_cur + PW'(1);

    assign res_dropped = (cmd_reg == CMD_STORE) && !in_range_reg;
    assign res_has     = (cmd_reg == CMD_CHECK) && in_range_reg
                         && (wp_reg[q_reg] != rp_reg[q_reg]);
    assign res_byte    = ((cmd_reg == CMD_POP) && in_range_reg) ? rdata_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_STORE && q_ok && in_len_sat != '0)
                        state_next = ST_WRITE;
                    else if (in_cmd == CMD_POP && q_ok)
                        state_next = ST_READ;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg == LEN_W'(1))
                    state_next = ST_RESULT;
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < DEVICE_QUEUES; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WRITE)
                wp_reg[q_reg] <= ptr_adv;
            if (state_reg == ST_READ)
                rp_reg[q_reg] <= ptr_adv;
            if (state_reg == ST_RESULT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= in_cmd;
            in_range_reg <= q_ok;
            q_reg        <= q_ok ? qsel8[QIW-1:0] : '0;
            cnt_reg      <= in_len_sat;
            bytes_reg    <= s_tdata[DATA_LSB +: DATA_W];
        end
        else if (state_reg == ST_WRITE)
        begin
            cnt_reg   <= cnt_reg - LEN_W'(1);
            bytes_reg <= bytes_reg >> BYTE_W;
        end
        if (state_reg == ST_RESULT && out_free)
            m_tdata_reg <= {{(M_TDATA_W - 10){1'b0}}, res_byte, res_has, res_dropped};
    end

    // single-port byte store
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            store_mem[{q_reg, ptr_cur}] <= bytes_reg[BYTE_W-1:0];
        else if (state_reg == ST_READ)
            rdata_reg <= store_mem[{q_reg, ptr_cur}];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CRDRB_ASSERT_SAME(a_write_cnt, state_reg == ST_WRITE, cnt_reg != '0, "write with zero count")
    `CRDRB_ASSERT_SAME(a_write_range, state_reg == ST_WRITE || state_reg == ST_READ, in_range_reg, "store access for out-of-range queue")
    `CRDRB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted a second item while busy")
    `CRDRB_ASSERT_SAME(a_one_kind, m_tvalid, !(m_tdata[0] && m_tdata[1]), "result flags both dropped and has_data")

endmodule
